// File: src/msws_pkg.sv
// Shared constants, types and pipeline records of the max square window sum unit.
package msws_pkg;

    // Largest matrix side that the prefix store holds.
    localparam int MAX_SIDE   = 64;
    localparam int SIDE_W     = $clog2(MAX_SIDE);
    localparam int ADDR_W     = 2 * SIDE_W;
    localparam int PMEM_DEPTH = 1 << ADDR_W;

    // Configuration registers.
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = CFG_IDX_W'(1);
    localparam logic [CFG_W-1:0]     MATRIX_SIZE_RST = CFG_W'(8);
    localparam logic [CFG_W-1:0]     WINDOW_SIZE_RST = CFG_W'(3);

    // Width used to compare positions against the configured sizes.
    localparam int CMP_W = (CFG_W > SIDE_W + 1) ? CFG_W : SIDE_W + 1;

    localparam int CELL_W = 16;
    localparam int SUM_W  = 28;

    typedef logic signed [CELL_W-1:0] t_cell;
    typedef logic signed [SUM_W-1:0]  t_sum;

    localparam t_sum SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Result queue.
    localparam int RES_DEPTH = 8;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    typedef struct packed {
        t_sum best_sum;
        logic window_found;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_push;

    // Stage 1: prefix sum of the cell.
    typedef struct packed {
        logic              valid;
        t_cell             cell_val;
        logic [SIDE_W-1:0] row;
        logic [SIDE_W-1:0] col;
        logic [SIDE_W-1:0] kcol;
        logic              first_row;
        logic              first_col;
        logic              k_zero;
        logic              kcol_zero;
        logic              win;
        logic              last;
        logic              fwd_up;
        logic              fwd_k;
    } t_s1;

    // Stage 2: vertical strip sum.
    typedef struct packed {
        logic              valid;
        t_sum              p;
        t_sum              upk;
        logic [SIDE_W-1:0] col;
        logic [SIDE_W-1:0] kcol;
        logic              kcol_zero;
        logic              win;
        logic              last;
    } t_s2;

    // Stage 3: window sum.
    typedef struct packed {
        logic valid;
        t_sum v;
        logic kcol_zero;
        logic win;
        logic last;
    } t_s3;

    // Stage 4: running maximum.
    typedef struct packed {
        logic valid;
        t_sum w;
        logic win;
        logic last;
    } t_s4;

endpackage

// File: src/msws_if.sv
// Valid/ready stream interfaces for the cell input and the result output.
interface msws_in_if;
    import msws_pkg::*;

    logic  valid;
    logic  ready;
    t_cell cell_value;

    modport source (output valid, output cell_value, input ready);
    modport sink (input valid, input cell_value, output ready);
endinterface

interface msws_out_if;
    import msws_pkg::*;

    logic valid;
    logic ready;
    t_sum best_sum;
    logic window_found;

    modport source (output valid, output best_sum, output window_found, input ready);
    modport sink (input valid, input best_sum, input window_found, output ready);
endinterface

// File: src/msws_fifo.sv
// Result queue between the window pipeline and the output channel.
module msws_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  msws_pkg::t_push i_push,
    msws_out_if.source      o_result
);
    import msws_pkg::*;

    t_result              r_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0] r_wr_ptr;
    logic [RES_PTR_W-1:0] r_rd_ptr;
    logic [RES_CNT_W-1:0] r_count;
    logic                 w_pop;

    assign o_result.valid        = (r_count != '0);
    assign o_result.best_sum     = r_mem[r_rd_ptr].best_sum;
    assign o_result.window_found = r_mem[r_rd_ptr].window_found;
    assign w_pop                 = o_result.valid && o_result.ready;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= (r_wr_ptr == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push.valid && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push.valid && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: src/max_square_window_sum_unit.sv
// Top level of the max square window sum unit: prefix store pipeline and control.
//
// Usage: the matrix_size (N) and window_size (K) registers are written through the
// plain write port (i_cfg_we, i_cfg_index, i_cfg_data) while the unit is idle.
// Cells of an N by N matrix arrive in row-major order on the i_cell channel, one
// item per cycle at full rate. Every cell updates a 2D prefix sum held in a
// synchronous memory; a second, row-sized memory holds K-row strip sums so that
// a window sum needs only one more read. Each cell costs two reads and one write
// of the prefix memory, so the sustained rate is one cell per cycle.
// After the last cell of a matrix one item leaves on o_result: the largest
// window sum and a found flag, which is zero when K exceeds N. The result
// passes through stages 1 to 4 and the result queue before it is offered.
// Results wait in an 8-entry queue. Cells that do not end a matrix are always
// taken; the last cell of a matrix is held off only while 8 results are queued
// or in flight, so a stalled receiver stops the input only at matrix ends.
// Reset restores N = 8 and K = 3 and clears position, maximum and queue. The
// prefix memory is not cleared: each entry is written before it is read.
module max_square_window_sum_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [msws_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [msws_pkg::CFG_W-1:0]      i_cfg_data,
    msws_in_if.sink                         i_cell,
    msws_out_if.source                      o_result
);
    import msws_pkg::*;

    // Configuration registers.
    logic [CFG_W-1:0] r_matrix_size;
    logic [CFG_W-1:0] r_window_size;

    // Position of the next cell.
    logic [SIDE_W-1:0] r_row;
    logic [SIDE_W-1:0] r_col;

    // Memories: 2D prefix sums and the strip sums of the current row.
    t_sum r_pmem [PMEM_DEPTH];
    t_sum r_vmem [MAX_SIDE];
    t_sum r_up_rd;
    t_sum r_k_rd;
    t_sum r_vk_rd;

    // Pipeline stages and carried values.
    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;
    t_s3  r_s3, n_s3;
    t_s4  r_s4, n_s4;
    t_sum r_prev_p;
    t_sum r_prev_up;

    // Running maximum of the current matrix.
    t_sum r_best;
    logic r_seen;

    // Results queued or in flight.
    logic [RES_CNT_W-1:0] r_credit;

    logic [CMP_W-1:0]  w_n_ext;
    logic [CMP_W-1:0]  w_n_eff;
    logic [CMP_W-1:0]  w_k_eff;
    logic [CMP_W-1:0]  w_krow_full;
    logic [CMP_W-1:0]  w_kcol_full;
    logic [ADDR_W-1:0] w_up_addr;
    logic [ADDR_W-1:0] w_k_addr;
    logic [ADDR_W-1:0] w_s1_addr;
    logic              w_last_col;
    logic              w_last_row;
    logic              w_last;
    logic              w_in_acc;
    logic              w_out_acc;
    t_sum              w_up;
    t_sum              w_left;
    t_sum              w_diag;
    t_sum              w_p;
    t_sum              w_upk;
    t_sum              w_v;
    t_sum              w_w;
    t_sum              w_best_new;
    logic              w_seen_new;
    t_push             w_push;

    // ------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_size <= MATRIX_SIZE_RST;
            r_window_size <= WINDOW_SIZE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MATRIX_SIZE: r_matrix_size <= i_cfg_data;
                CFG_WINDOW_SIZE: r_window_size <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: position bookkeeping and prefix memory read addresses.
    // A size of zero counts as one; N is capped at the store side.
    // ------------------------------------------------------------------
    always_comb begin
        w_n_ext = CMP_W'(r_matrix_size);
        if (w_n_ext == '0) begin
            w_n_eff = CMP_W'(1);
        end else if (w_n_ext > CMP_W'(MAX_SIDE)) begin
            w_n_eff = CMP_W'(MAX_SIDE);
        end else begin
            w_n_eff = w_n_ext;
        end
        w_k_eff = (r_window_size == '0) ? CMP_W'(1) : CMP_W'(r_window_size);
    end

    assign w_last_col  = (CMP_W'(r_col) + CMP_W'(1)) >= w_n_eff;
    assign w_last_row  = (CMP_W'(r_row) + CMP_W'(1)) >= w_n_eff;
    assign w_last      = w_last_col && w_last_row;
    assign w_krow_full = CMP_W'(r_row) - w_k_eff;
    assign w_kcol_full = CMP_W'(r_col) - w_k_eff;
    assign w_up_addr   = {r_row - SIDE_W'(1), r_col};
    assign w_k_addr    = {w_krow_full[SIDE_W-1:0], r_col};
    assign w_s1_addr   = {r_s1.row, r_s1.col};

    // The last cell of a matrix needs a free slot in the result queue.
    assign i_cell.ready = !w_last || (r_credit < RES_CNT_W'(RES_DEPTH));
    assign w_in_acc     = i_cell.valid && i_cell.ready;
    assign w_out_acc    = o_result.valid && o_result.ready;

    always_comb begin
        n_s1           = r_s1;
        n_s1.valid     = w_in_acc;
        n_s1.cell_val  = i_cell.cell_value;
        n_s1.row       = r_row;
        n_s1.col       = r_col;
        n_s1.kcol      = w_kcol_full[SIDE_W-1:0];
        n_s1.first_row = (r_row == '0);
        n_s1.first_col = (r_col == '0);
        n_s1.k_zero    = CMP_W'(r_row) < w_k_eff;
        n_s1.kcol_zero = CMP_W'(r_col) < w_k_eff;
        n_s1.win       = ((CMP_W'(r_row) + CMP_W'(1)) >= w_k_eff)
                         && ((CMP_W'(r_col) + CMP_W'(1)) >= w_k_eff);
        n_s1.last      = w_last;
        // The entry written at this very edge is not yet visible in the
        // memory read, so it is taken from the stage 1 result instead.
        n_s1.fwd_up    = r_s1.valid && (w_up_addr == w_s1_addr);
        n_s1.fwd_k     = r_s1.valid && (w_k_addr == w_s1_addr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (w_in_acc) begin
            if (!w_last_col) begin
                r_col <= r_col + 1'b1;
            end else begin
                r_col <= '0;
                r_row <= w_last_row ? '0 : r_row + 1'b1;
            end
        end
    end

    // Prefix memory: two reads at accept, one write from stage 1.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_up_rd <= r_pmem[w_up_addr];
            r_k_rd  <= r_pmem[w_k_addr];
        end
        if (r_s1.valid) begin
            r_pmem[w_s1_addr] <= w_p;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: P(r,c) = cell + P(r-1,c) + P(r,c-1) - P(r-1,c-1).
    // The left term is the previous cell's prefix sum and the diagonal term
    // is the previous cell's upper term; terms outside the matrix are zero.
    // ------------------------------------------------------------------
    always_comb begin
        w_up   = r_s1.first_row ? '0 : (r_s1.fwd_up ? r_prev_p : r_up_rd);
        w_left = r_s1.first_col ? '0 : r_prev_p;
        w_diag = r_s1.first_col ? '0 : r_prev_up;
        w_p    = t_sum'(r_s1.cell_val) + w_up + w_left - w_diag;
        w_upk  = r_s1.k_zero ? '0 : (r_s1.fwd_k ? r_prev_p : r_k_rd);
    end

    always_ff @(posedge i_clk) begin
        if (r_s1.valid) begin
            r_prev_p  <= w_p;
            r_prev_up <= w_up;
        end
    end

    always_comb begin
        n_s2           = r_s2;
        n_s2.valid     = r_s1.valid;
        n_s2.p         = w_p;
        n_s2.upk       = w_upk;
        n_s2.col       = r_s1.col;
        n_s2.kcol      = r_s1.kcol;
        n_s2.kcol_zero = r_s1.kcol_zero;
        n_s2.win       = r_s1.win;
        n_s2.last      = r_s1.last;
    end

    // ------------------------------------------------------------------
    // Stage 2: strip sum V(r,c) = P(r,c) - P(r-K,c), kept per column of the
    // current row. V(r,c-K) was written by an earlier cell of the row, before this read.
    // ------------------------------------------------------------------
    assign w_v = r_s2.p - r_s2.upk;

    always_ff @(posedge i_clk) begin
        if (r_s2.valid) begin
            r_vmem[r_s2.col] <= w_v;
            r_vk_rd          <= r_vmem[r_s2.kcol];
        end
    end

    always_comb begin
        n_s3           = r_s3;
        n_s3.valid     = r_s2.valid;
        n_s3.v         = w_v;
        n_s3.kcol_zero = r_s2.kcol_zero;
        n_s3.win       = r_s2.win;
        n_s3.last      = r_s2.last;
    end

    // ------------------------------------------------------------------
    // Stage 3: window sum W = V(r,c) - V(r,c-K).
    // ------------------------------------------------------------------
    assign w_w = r_s3.v - (r_s3.kcol_zero ? '0 : r_vk_rd);

    always_comb begin
        n_s4       = r_s4;
        n_s4.valid = r_s3.valid;
        n_s4.w     = w_w;
        n_s4.win   = r_s3.win;
        n_s4.last  = r_s3.last;
    end

    // ------------------------------------------------------------------
    // Stage 4: running maximum; the matrix's last cell pushes the result.
    // ------------------------------------------------------------------
    always_comb begin
        if (r_s4.win && (!r_seen || (r_s4.w > r_best))) begin
            w_best_new = r_s4.w;
        end else begin
            w_best_new = r_best;
        end
        w_seen_new              = r_seen || r_s4.win;
        w_push.valid            = r_s4.valid && r_s4.last;
        w_push.res.best_sum     = w_seen_new ? w_best_new : SUM_MIN;
        w_push.res.window_found = w_seen_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= SUM_MIN;
            r_seen <= 1'b0;
        end else if (r_s4.valid) begin
            if (r_s4.last) begin
                r_best <= SUM_MIN;
                r_seen <= 1'b0;
            end else begin
                r_best <= w_best_new;
                r_seen <= w_seen_new;
            end
        end
    end

    // Stage registers; only the valid flags are reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
            r_s3.valid <= 1'b0;
            r_s4.valid <= 1'b0;
        end else begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
            r_s4 <= n_s4;
        end
    end

    // Result slots: taken when a last cell enters, returned when a result leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else if ((w_in_acc && w_last) && !w_out_acc) begin
            r_credit <= r_credit + 1'b1;
        end else if (!(w_in_acc && w_last) && w_out_acc) begin
            r_credit <= r_credit - 1'b1;
        end
    end

    msws_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .o_result (o_result)
    );

`ifndef ASSERT_OFF
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= RES_CNT_W'(RES_DEPTH))
        else $error("result slot count exceeds queue depth");

    a_push_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.valid |-> (r_credit != '0))
        else $error("result pushed without a reserved slot");

    a_output_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (r_credit != '0))
        else $error("result offered without a reserved slot");

    a_fwd_up_first_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1.valid && r_s1.fwd_up) |-> r_s1.first_col)
        else $error("upper prefix forwarded away from column zero");
`endif

endmodule
